>>> rtl/core/two_choice_bin_slot_allocator_assert.svh
// assertion helpers for the bin slot allocator
`ifndef TWO_CHOICE_BIN_SLOT_ALLOCATOR_ASSERT_SVH
`define TWO_CHOICE_BIN_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define TCBSA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCBSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tcbsa_pkg.sv
package tcbsa_pkg;

	localparam int NUM_BINS   = 16;
	localparam int BIN_SLOTS  = 127;
	localparam int BIN_AW     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int BIN_DEPTH  = 1 << BIN_AW;
	localparam int SLOT_AW    = BIN_AW + 7;
	localparam int SLOT_DEPTH = 1 << SLOT_AW;

	localparam logic [6:0] SLOTS7      = 7'(BIN_SLOTS);
	localparam logic [7:0] SECOND_MARK = 8'(1 << 7);
	localparam logic [7:0] REF_FULL    = 8'((1 << 8) - 1);

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_FREE   = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] item_key;
		logic [63:0] item_value;
		logic [7:0]  tiny_ref;
		logic [3:0]  first_bin;
		logic [3:0]  second_bin;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [7:0]  ref_out;
		logic [63:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic [6:0] head;
		logic [6:0] count;
	} bin_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ALLOC_B1,
		ST_ALLOC_PICK,
		ST_ALLOC_DONE,
		ST_OP_DONE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic take_in;
		logic a1_step;
		logic a2_step;
		logic fin_alloc;
		logic fin_op;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_alloc;
		logic out_free;
	} sts_t;

	function automatic logic [BIN_AW-1:0] bin_addr(input logic [3:0] b);
		logic [BIN_AW+3:0] t;
		t = {{BIN_AW{1'b0}}, b};
		return t[BIN_AW-1:0];
	endfunction

	function automatic logic bin_ok(input logic [3:0] b);
		return 32'(b) < NUM_BINS;
	endfunction

endpackage

>>> rtl/core/two_choice_bin_slot_allocator.sv
// channel  | handshake            | payload
// ---------+----------------------+------------------
// request  | req_valid, req_stall | req (req_t)
// response | rsp_valid, rsp_stall | rsp (rsp_t)
//
// After reset a clearing pass writes every slot link and bin state, one slot per cycle;
// it covers all SLOT_DEPTH slots (2048 at 16 bins), and req_stall stays high until it ends.
// Query, update, free: slot and bin reads, then compare and write back.
// Allocate: the bin state memory has a single read port, so its two bin reads come in turn,
// then the head slot link read, then write back.
// One request is in flight; a new one is taken while the last response waits on rsp_stall.
module two_choice_bin_slot_allocator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  tcbsa_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output tcbsa_pkg::rsp_t   rsp
);

	tcbsa_pkg::cmd_t cmd;
	tcbsa_pkg::sts_t sts;

	tcbsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcbsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

>>> rtl/core/tcbsa_ram.sv
module tcbsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/tcbsa_ctrl.sv
module tcbsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  tcbsa_pkg::sts_t   sts,
	output tcbsa_pkg::cmd_t   cmd
);

	tcbsa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcbsa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcbsa_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_d = tcbsa_pkg::ST_IDLE;
			end
			tcbsa_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = sts.in_alloc ? tcbsa_pkg::ST_ALLOC_B1 : tcbsa_pkg::ST_OP_DONE;
				end
			end
			tcbsa_pkg::ST_ALLOC_B1:   state_d = tcbsa_pkg::ST_ALLOC_PICK;
			tcbsa_pkg::ST_ALLOC_PICK: state_d = tcbsa_pkg::ST_ALLOC_DONE;
			tcbsa_pkg::ST_ALLOC_DONE: begin
				if (sts.out_free) state_d = tcbsa_pkg::ST_IDLE;
			end
			tcbsa_pkg::ST_OP_DONE: begin
				if (sts.out_free) state_d = tcbsa_pkg::ST_IDLE;
			end
			default: state_d = tcbsa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			tcbsa_pkg::ST_CLEAR:      cmd.clr_step = 1'b1;
			tcbsa_pkg::ST_IDLE: begin
				req_stall   = 1'b0;
				cmd.take_in = req_valid;
			end
			tcbsa_pkg::ST_ALLOC_B1:   cmd.a1_step   = 1'b1;
			tcbsa_pkg::ST_ALLOC_PICK: cmd.a2_step   = 1'b1;
			tcbsa_pkg::ST_ALLOC_DONE: cmd.fin_alloc = sts.out_free;
			tcbsa_pkg::ST_OP_DONE:    cmd.fin_op    = sts.out_free;
			default: ;
		endcase
	end

	`include "two_choice_bin_slot_allocator_assert.svh"

	`TCBSA_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command")
	`TCBSA_ASSERT_NOW(a_fin_free, cmd.fin_alloc || cmd.fin_op, sts.out_free,
		"result beat loaded while output busy")
	`TCBSA_ASSERT_NEXT(a_b1_pick, state_q == tcbsa_pkg::ST_ALLOC_B1,
		state_q == tcbsa_pkg::ST_ALLOC_PICK, "allocate sequence broken")
	`TCBSA_ASSERT_NEXT(a_fin_idle, cmd.fin_alloc || cmd.fin_op,
		state_q == tcbsa_pkg::ST_IDLE, "no return to idle after result beat")

endmodule

>>> rtl/core/tcbsa_dp.sv
module tcbsa_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  tcbsa_pkg::req_t   req,
	input  tcbsa_pkg::cmd_t   cmd,
	output tcbsa_pkg::sts_t   sts,
	output tcbsa_pkg::rsp_t   rsp,
	output logic              rsp_valid,
	input  logic              rsp_stall
);

	tcbsa_pkg::req_t            req_q;
	logic [tcbsa_pkg::SLOT_AW-1:0] clr_cnt_q;
	tcbsa_pkg::bin_t            b0st_q;
	logic                       op_bad_q;
	logic [3:0]                 op_bin_q;
	logic [6:0]                 op_p_q;
	logic                       alloc_any_q;
	logic                       alloc_second_q;
	logic [3:0]                 alloc_bin_q;
	logic [6:0]                 alloc_head_q;
	logic [6:0]                 alloc_count_q;
	tcbsa_pkg::rsp_t            rsp_q;
	logic                       rsp_valid_q;

	// incoming pointer decode
	logic       in_second;
	logic [7:0] in_p;
	logic [3:0] in_bin;
	logic       in_bad;
	logic [6:0] in_slot;

	assign in_second = (req.tiny_ref & tcbsa_pkg::SECOND_MARK) != 8'd0;
	assign in_p      = in_second ? (req.tiny_ref ^ tcbsa_pkg::REF_FULL) : req.tiny_ref;
	assign in_bin    = in_second ? req.second_bin : req.first_bin;
	assign in_slot   = in_p[6:0] - 7'd1;
	assign in_bad    = (req.tiny_ref == 8'd0) || (req.tiny_ref == tcbsa_pkg::REF_FULL) ||
		!tcbsa_pkg::bin_ok(in_bin) || (in_p == 8'd0) || (in_p > {1'b0, tcbsa_pkg::SLOTS7});

	// memories
	logic                          key_we, key_re, val_we, val_re, bin_we, bin_re;
	logic [tcbsa_pkg::SLOT_AW-1:0] key_waddr, key_raddr, val_waddr, val_raddr;
	logic [63:0]                   key_wdata, key_rdata, val_wdata, val_rdata;
	logic [tcbsa_pkg::BIN_AW-1:0]  bin_waddr, bin_raddr;
	tcbsa_pkg::bin_t               bin_wdata, bin_rdata;

	tcbsa_ram #(.WIDTH(64), .DEPTH(tcbsa_pkg::SLOT_DEPTH)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
		.re(key_re), .raddr(key_raddr), .rdata(key_rdata)
	);

	tcbsa_ram #(.WIDTH(64), .DEPTH(tcbsa_pkg::SLOT_DEPTH)) u_val_ram (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
		.re(val_re), .raddr(val_raddr), .rdata(val_rdata)
	);

	tcbsa_ram #(.WIDTH($bits(tcbsa_pkg::bin_t)), .DEPTH(tcbsa_pkg::BIN_DEPTH)) u_bin_ram (
		.clk(clk), .we(bin_we), .waddr(bin_waddr), .wdata(bin_wdata),
		.re(bin_re), .raddr(bin_raddr), .rdata(bin_rdata)
	);

	// two-choice pick: b0 state held, b1 state on the read port
	logic            can0, can1, pick_second;
	logic [3:0]      pick_bin;
	tcbsa_pkg::bin_t pick_st;

	assign can0 = tcbsa_pkg::bin_ok(req_q.first_bin) && (b0st_q.count < tcbsa_pkg::SLOTS7) &&
		(b0st_q.head != 7'd0) && (b0st_q.head <= tcbsa_pkg::SLOTS7);
	assign can1 = tcbsa_pkg::bin_ok(req_q.second_bin) &&
		(bin_rdata.count < tcbsa_pkg::SLOTS7) &&
		(bin_rdata.head != 7'd0) && (bin_rdata.head <= tcbsa_pkg::SLOTS7);
	assign pick_second = !can0 || (can1 && (b0st_q.count > bin_rdata.count));
	assign pick_bin    = pick_second ? req_q.second_bin : req_q.first_bin;
	assign pick_st     = pick_second ? bin_rdata : b0st_q;

	logic op_match;
	assign op_match = !op_bad_q && (key_rdata == req_q.item_key);

	always_comb begin
		key_re    = cmd.take_in || cmd.a2_step;
		key_raddr = cmd.take_in ? {tcbsa_pkg::bin_addr(in_bin), in_slot}
			: {tcbsa_pkg::bin_addr(pick_bin), pick_st.head - 7'd1};

		val_re    = cmd.take_in;
		val_raddr = {tcbsa_pkg::bin_addr(in_bin), in_slot};

		bin_re    = cmd.take_in || cmd.a1_step;
		priority if (cmd.take_in) begin
			bin_raddr = tcbsa_pkg::bin_addr((req.req_type == tcbsa_pkg::OP_ALLOC) ?
				req.first_bin : in_bin);
		end else begin
			bin_raddr = tcbsa_pkg::bin_addr(req_q.second_bin);
		end

		key_we    = 1'b0;
		key_waddr = clr_cnt_q;
		key_wdata = 64'(clr_cnt_q[6:0]) + 64'd2;
		val_we    = 1'b0;
		val_waddr = {tcbsa_pkg::bin_addr(op_bin_q), op_p_q - 7'd1};
		val_wdata = req_q.item_value;
		bin_we    = 1'b0;
		bin_waddr = clr_cnt_q[tcbsa_pkg::SLOT_AW-1:7];
		bin_wdata = '{head: 7'd1, count: 7'd0};

		priority if (cmd.clr_step) begin
			key_we = 1'b1;
			bin_we = clr_cnt_q[6:0] == 7'd0;
		end else if (cmd.fin_alloc) begin
			key_we    = alloc_any_q;
			key_waddr = {tcbsa_pkg::bin_addr(alloc_bin_q), alloc_head_q - 7'd1};
			key_wdata = req_q.item_key;
			val_we    = alloc_any_q;
			val_waddr = key_waddr;
			bin_we    = alloc_any_q;
			bin_waddr = tcbsa_pkg::bin_addr(alloc_bin_q);
			bin_wdata = '{head: key_rdata[6:0], count: alloc_count_q + 7'd1};
		end else if (cmd.fin_op) begin
			val_we    = op_match && (req_q.req_type == tcbsa_pkg::OP_UPDATE);
			key_we    = op_match && (req_q.req_type == tcbsa_pkg::OP_FREE);
			key_waddr = {tcbsa_pkg::bin_addr(op_bin_q), op_p_q - 7'd1};
			key_wdata = 64'(bin_rdata.head);
			bin_we    = key_we;
			bin_waddr = tcbsa_pkg::bin_addr(op_bin_q);
			bin_wdata = '{head: op_p_q,
				count: (bin_rdata.count != 7'd0) ? bin_rdata.count - 7'd1 : 7'd0};
		end else begin
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.fin_alloc || cmd.fin_op) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			req_q    <= req;
			op_bad_q <= in_bad;
			op_bin_q <= in_bin;
			op_p_q   <= in_p[6:0];
		end
		if (cmd.a1_step) b0st_q <= bin_rdata;
		if (cmd.a2_step) begin
			alloc_any_q    <= can0 || can1;
			alloc_second_q <= pick_bin == req_q.second_bin;
			alloc_bin_q    <= pick_bin;
			alloc_head_q   <= pick_st.head;
			alloc_count_q  <= pick_st.count;
		end
		if (cmd.fin_alloc) begin
			rsp_q.ok         <= alloc_any_q;
			rsp_q.read_value <= 64'd0;
			if (!alloc_any_q) begin
				rsp_q.ref_out <= tcbsa_pkg::REF_FULL;
			end else if (alloc_second_q) begin
				rsp_q.ref_out <= {1'b0, alloc_head_q} ^ tcbsa_pkg::REF_FULL;
			end else begin
				rsp_q.ref_out <= {1'b0, alloc_head_q};
			end
		end else if (cmd.fin_op) begin
			rsp_q.ok         <= op_match;
			rsp_q.ref_out    <= 8'd0;
			rsp_q.read_value <= (op_match && (req_q.req_type == tcbsa_pkg::OP_QUERY)) ?
				val_rdata : 64'd0;
		end
	end

	assign sts.clr_last = clr_cnt_q == tcbsa_pkg::SLOT_AW'(tcbsa_pkg::SLOT_DEPTH - 1);
	assign sts.in_alloc = req.req_type == tcbsa_pkg::OP_ALLOC;
	assign sts.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp          = rsp_q;
	assign rsp_valid    = rsp_valid_q;

endmodule
